// File: rtl/ordered_list_engine_defines.svh
// ----------------------------------------------------------------------------
// Ordered list engine assertion macros
// Assertion helpers; they expand to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_ENGINE_DEFINES_SVH
`define ORDERED_LIST_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS
`define OLE_ASSERT_IMPL(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("ordered_list_engine: assertion failed");
`define OLE_ASSERT_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("ordered_list_engine: assertion failed");
`else
`define OLE_ASSERT_IMPL(name, clk, rst, pre, post)
`define OLE_ASSERT_NEXT(name, clk, rst, pre, post)
`endif

`endif

// File: rtl/ole_pkg.sv
// ----------------------------------------------------------------------------
// Ordered list engine package
// Opcodes, sequencer states and the structs between top level and sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package ole_pkg;

   localparam int POS_W   = 5;
   localparam int VALUE_W = 32;
   localparam int OUT_W   = 5;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_SEARCH = 2'd2;

   localparam logic [OUT_W-1:0] NOT_FOUND = {OUT_W{1'b1}};

   typedef enum logic {
      SEQ_OP_INSERT,
      SEQ_OP_SEARCH
   } seq_op_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_SHIFT_RD,
      SEQ_SHIFT_WR,
      SEQ_PUT,
      SEQ_SRCH_RD,
      SEQ_SRCH_CMP
   } seq_state_type;

   typedef struct packed {
      logic               go;
      seq_op_type         op;
      logic [POS_W-1:0]   pos;
      logic [VALUE_W-1:0] value;
   } seq_cmd_type;

   typedef struct packed {
      logic             done;
      logic             is_insert;
      logic             found;
      logic [OUT_W-1:0] index;
   } seq_done_type;

endpackage

`default_nettype wire

// File: rtl/ordered_list_engine.sv
// ----------------------------------------------------------------------------
// Ordered list engine
// Ordered list of up to MAX_ENTRIES signed 32-bit values with insert at a
// position, remove of the last entry and search for the first equal entry.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken on a rising edge with start high and busy low.
//   Every transaction returns one result on rsp_* with rsp_strobe high for
//   exactly one cycle; the receiver cannot hold it off.
// Remove, opcode three, a rejected insert and a search of an empty list
// respond through the result registers alone, without the sequencer. An insert
// shifts entries from the count down to the position, then writes the value;
// a search compares entries from index zero up to the first hit or the last.
// Each shifted or compared entry is read and then written or compared on
// the single read and write port pair of the entry RAM, using one counter.
// busy stays high until the result is registered; a new transaction can
// be taken in the cycle the result is strobed.
// Reset clears the entry count and the sequencer; entry contents are not
// cleared and need no pass, as only entries below the count are read.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ordered_list_engine_defines.svh"

module ordered_list_engine #(
   parameter int MAX_ENTRIES = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic [1:0]                          req_opcode,
   input  wire logic signed [ole_pkg::VALUE_W-1:0]  req_value,
   input  wire logic [ole_pkg::POS_W-1:0]           req_position,
   output logic                                     rsp_strobe,
   output logic                                     rsp_status,
   output logic signed [ole_pkg::OUT_W-1:0]         rsp_found_index,
   output logic [ole_pkg::OUT_W-1:0]                rsp_entry_count
);

   localparam int LEN_W = $clog2(MAX_ENTRIES + 1);
   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CMP_W = (LEN_W > ole_pkg::POS_W) ? LEN_W : ole_pkg::POS_W;

   logic [LEN_W-1:0]                  length_ff, length_in;
   logic [LEN_W+ole_pkg::OUT_W-1:0]   length_wide;
   logic                              rsp_strobe_ff, rsp_strobe_in;
   logic                              rsp_status_ff, rsp_status_in;
   logic [ole_pkg::OUT_W-1:0]         rsp_found_index_ff, rsp_found_index_in;
   logic [ole_pkg::OUT_W-1:0]         rsp_entry_count_ff;

   logic                              accept, imm, imm_status, ins_ok;
   ole_pkg::seq_cmd_type              cmd;
   ole_pkg::seq_done_type             done;

   logic                              wr_en;
   logic [IDX_W-1:0]                  wr_addr, rd_addr;
   logic [ole_pkg::VALUE_W-1:0]       wr_data, rd_data;

   assign accept = start && !busy;
   assign ins_ok = (CMP_W'(req_position) <= CMP_W'(length_ff))
                   && (length_ff != LEN_W'(MAX_ENTRIES));

   always_comb begin
      cmd        = '0;
      cmd.op     = ole_pkg::SEQ_OP_INSERT;
      cmd.pos    = req_position;
      cmd.value  = req_value;
      imm        = 1'b0;
      imm_status = 1'b0;
      length_in  = length_ff;
      if (accept) begin
         unique case (req_opcode)
            ole_pkg::OP_INSERT: begin
               if (ins_ok) begin
                  cmd.go = 1'b1;
               end else begin
                  imm        = 1'b1;
                  imm_status = 1'b1;
               end
            end
            ole_pkg::OP_REMOVE: begin
               imm = 1'b1;
               if (length_ff == '0) begin
                  imm_status = 1'b1;
               end else begin
                  length_in = length_ff - LEN_W'(1);
               end
            end
            ole_pkg::OP_SEARCH: begin
               if (length_ff == '0) begin
                  imm = 1'b1;
               end else begin
                  cmd.go = 1'b1;
                  cmd.op = ole_pkg::SEQ_OP_SEARCH;
               end
            end
            default: begin
               imm        = 1'b1;
               imm_status = 1'b1;
            end
         endcase
      end
      if (done.done && done.is_insert) begin
         length_in = length_ff + LEN_W'(1);
      end
   end

   assign length_wide        = {{ole_pkg::OUT_W{1'b0}}, length_in};
   assign rsp_strobe_in      = imm || done.done;
   assign rsp_status_in      = done.done ? 1'b0 : imm_status;
   assign rsp_found_index_in = (done.done && done.found) ? done.index : ole_pkg::NOT_FOUND;

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff     <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         length_ff     <= length_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff      <= rsp_status_in;
      rsp_found_index_ff <= rsp_found_index_in;
      rsp_entry_count_ff <= length_wide[ole_pkg::OUT_W-1:0];
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_index = rsp_found_index_ff;
   assign rsp_entry_count = rsp_entry_count_ff;

   ole_seq #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .LEN_W       (LEN_W),
      .IDX_W       (IDX_W)
   ) u_seq (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .length  (length_ff),
      .rd_data (rd_data),
      .busy    (busy),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .done    (done)
   );

   ole_ram #(
      .WIDTH  (ole_pkg::VALUE_W),
      .DEPTH  (MAX_ENTRIES),
      .ADDR_W (IDX_W)
   ) u_entries (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // every transaction either responds next cycle or occupies the sequencer
   `OLE_ASSERT_NEXT(a_accept_progress, clock, reset, accept, rsp_strobe_ff || busy)
   // sequencer completion always produces a result
   `OLE_ASSERT_IMPL(a_done_strobe, clock, reset, $fell(busy), rsp_strobe_ff)
   // no result while a sequenced transaction is in flight
   `OLE_ASSERT_IMPL(a_busy_quiet, clock, reset, busy, !rsp_strobe_ff)

endmodule

`default_nettype wire

// File: rtl/ole_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ole_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// File: rtl/ole_seq.sv
// ----------------------------------------------------------------------------
// Ordered list engine sequencer
// Walks the entry RAM one step at a time: shifts entries back for an insert,
// compares one entry per pass for a search.
// ----------------------------------------------------------------------------
`default_nettype none

module ole_seq #(
   parameter int MAX_ENTRIES = 16,
   parameter int LEN_W = $clog2(MAX_ENTRIES + 1),
   parameter int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire ole_pkg::seq_cmd_type          cmd,
   input  wire logic [LEN_W-1:0]              length,
   input  wire logic [ole_pkg::VALUE_W-1:0]   rd_data,
   output logic                               busy,
   output logic                               wr_en,
   output logic [IDX_W-1:0]                   wr_addr,
   output logic [ole_pkg::VALUE_W-1:0]        wr_data,
   output logic [IDX_W-1:0]                   rd_addr,
   output ole_pkg::seq_done_type              done
);

   localparam int CMP_W = (LEN_W > ole_pkg::POS_W) ? LEN_W : ole_pkg::POS_W;

   ole_pkg::seq_state_type state_ff, state_in;
   logic [LEN_W-1:0]              k_ff, k_in;
   logic [LEN_W-1:0]              km1, kp1;
   logic [ole_pkg::POS_W-1:0]     pos_ff;
   logic [ole_pkg::VALUE_W-1:0]   value_ff;
   logic [LEN_W+ole_pkg::OUT_W-1:0] k_wide;
   logic                          match, at_pos, last, start_at_pos;

   assign km1          = k_ff - LEN_W'(1);
   assign kp1          = k_ff + LEN_W'(1);
   assign k_wide       = {{ole_pkg::OUT_W{1'b0}}, k_ff};
   assign match        = (rd_data == value_ff);
   assign at_pos       = (CMP_W'(km1) == CMP_W'(pos_ff));
   assign last         = (kp1 == length);
   assign start_at_pos = (CMP_W'(length) == CMP_W'(cmd.pos));
   assign busy         = (state_ff != ole_pkg::SEQ_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ole_pkg::SEQ_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff <= k_in;
      if (cmd.go) begin
         pos_ff   <= cmd.pos;
         value_ff <= cmd.value;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ole_pkg::SEQ_IDLE: begin
            if (cmd.go) begin
               if (cmd.op == ole_pkg::SEQ_OP_INSERT) begin
                  state_in = start_at_pos ? ole_pkg::SEQ_PUT : ole_pkg::SEQ_SHIFT_RD;
               end else begin
                  state_in = ole_pkg::SEQ_SRCH_RD;
               end
            end
         end
         ole_pkg::SEQ_SHIFT_RD: state_in = ole_pkg::SEQ_SHIFT_WR;
         ole_pkg::SEQ_SHIFT_WR: state_in = at_pos ? ole_pkg::SEQ_PUT : ole_pkg::SEQ_SHIFT_RD;
         ole_pkg::SEQ_PUT:      state_in = ole_pkg::SEQ_IDLE;
         ole_pkg::SEQ_SRCH_RD:  state_in = ole_pkg::SEQ_SRCH_CMP;
         ole_pkg::SEQ_SRCH_CMP: begin
            state_in = (match || last) ? ole_pkg::SEQ_IDLE : ole_pkg::SEQ_SRCH_RD;
         end
         default:               state_in = ole_pkg::SEQ_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      k_in           = k_ff;
      wr_en          = 1'b0;
      wr_addr        = k_ff[IDX_W-1:0];
      wr_data        = rd_data;
      rd_addr        = k_ff[IDX_W-1:0];
      done           = '0;
      done.index     = ole_pkg::NOT_FOUND;
      unique case (state_ff)
         ole_pkg::SEQ_IDLE: begin
            if (cmd.go) begin
               k_in = (cmd.op == ole_pkg::SEQ_OP_INSERT) ? length : '0;
            end
         end
         ole_pkg::SEQ_SHIFT_RD: begin
            rd_addr = km1[IDX_W-1:0];
         end
         ole_pkg::SEQ_SHIFT_WR: begin
            wr_en = 1'b1;
            k_in  = km1;
         end
         ole_pkg::SEQ_PUT: begin
            wr_en          = 1'b1;
            wr_data        = value_ff;
            done.done      = 1'b1;
            done.is_insert = 1'b1;
         end
         ole_pkg::SEQ_SRCH_RD: begin
         end
         ole_pkg::SEQ_SRCH_CMP: begin
            if (match) begin
               done.done  = 1'b1;
               done.found = 1'b1;
               done.index = k_wide[ole_pkg::OUT_W-1:0];
            end else if (last) begin
               done.done = 1'b1;
            end else begin
               k_in = kp1;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire
